[rtl/iws_pkg.sv]
// Package with the shared types, constants and codes of the interval window statistics block.
package iws_pkg;

    localparam int unsigned MAX_INTERVALS_DEF = 64;
    localparam int unsigned MAX_CHANNELS_DEF  = 8;
    localparam int unsigned COUNT_BITS_DEF    = 20;
    localparam int unsigned VALUE_BITS_DEF    = 16;

    localparam int unsigned RES_W  = 48;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned SUM_W  = 64;
    localparam int unsigned SQ_W   = 64;

    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_SAMPLE = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;

    localparam logic [2:0] MODE_MEAN = 3'd0;
    localparam logic [2:0] MODE_VAR  = 3'd1;
    localparam logic [2:0] MODE_STD  = 3'd2;
    localparam logic [2:0] MODE_MIN  = 3'd3;
    localparam logic [2:0] MODE_MAX  = 3'd4;

    localparam logic [1:0] REG_STAT_MODE     = 2'd0;
    localparam logic [1:0] REG_INTERVAL_CNT  = 2'd1;
    localparam logic [1:0] REG_CHANNEL_CNT   = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [5:0]         interval_index;
        logic [2:0]         channel_index;
        logic [31:0]        start_time;
        logic [31:0]        end_time;
        logic [31:0]        sample_time;
        logic signed [15:0] sample_value;
    } t_req;

    typedef struct packed {
        logic signed [47:0] result_value;
        logic               empty_interval;
        logic               count_saturated;
        logic               bad_request;
    } t_res;

    // Request to the arithmetic unit and its answer.
    typedef struct packed {
        logic        go;
        logic [2:0]  mode;
        logic [31:0] n;
        logic        neg;
        logic [63:0] mag;
        logic [63:0] sqsum;
    } t_calc_req;

    typedef struct packed {
        logic        done;
        logic [63:0] mag;
        logic        neg;
    } t_calc_rsp;

endpackage

[rtl/iws_calc.sv]
// Multi-cycle arithmetic unit: mean, variance and standard deviation by multiply and shift-subtract steps.
module iws_calc (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  iws_pkg::t_calc_req i_req,
    output iws_pkg::t_calc_rsp o_rsp
);
    import iws_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MUL1 = 8'b0000_0010,
        S_MUL2 = 8'b0000_0100,
        S_SUB  = 8'b0000_1000,
        S_DIV  = 8'b0001_0000,
        S_SQRT = 8'b0010_0000,
        S_FIN  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic [2:0]   r_mode;
    logic         r_neg;
    logic [63:0]  r_n;
    logic [63:0]  r_mag;
    logic [127:0] r_a;       // product of n and sumsq / dividend shift register
    logic [127:0] r_b;
    logic [63:0]  r_d;       // divisor
    logic [63:0]  r_rem;
    logic [63:0]  r_q;
    logic         r_qhi;
    logic [7:0]   r_cnt;
    logic [63:0]  r_sv, r_sr, r_sb;
    logic [127:0] r_prod;
    logic [1:0]   r_phase;
    logic [63:0]  r_x;

    // Mul unit: 64x64 via four 32x32 partial products per step, one per cycle.
    logic [63:0]  mul_pp;
    logic [31:0]  mul_a, mul_b;
    assign mul_pp = {32'd0, mul_a} * {32'd0, mul_b};

    logic [64:0]  div_shift;
    logic         div_take;
    logic [63:0]  sq_t;
    logic         sq_ok;
    logic [127:0] pp_sum;
    logic [63:0]  nn_w;

    // Product accumulation helper: adds a 64-bit partial product at an offset that is a multiple of 32 bits.
    function automatic logic [127:0] acc_pp(input logic [127:0] acc, input logic [63:0] pp,
                                            input logic [1:0] sh);
        logic [127:0] ext;
        begin
            ext = {64'd0, pp} << {sh, 5'd0};
            acc_pp = acc + ext;
        end
    endfunction

    always_comb begin
        div_shift = {r_rem, r_a[127]};
        div_take  = div_shift[64] || (div_shift[63:0] >= r_d);
        sq_t      = r_sr + r_sb;
        sq_ok     = r_sv >= sq_t;
        mul_a     = r_phase[0] ? r_b[63:32] : r_b[31:0];
        mul_b     = r_cnt[0] ? r_d[63:32] : r_d[31:0];
        pp_sum    = acc_pp(r_prod, mul_pp, {1'b0, r_phase[0]} + {1'b0, r_cnt[0]});
        nn_w      = {32'd0, r_n[31:0]} * {32'd0, r_n[31:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_req.go) n_state = (i_req.mode == MODE_MEAN) ? S_DIV : S_MUL1;
            S_MUL1: if (r_cnt == 8'd1 && r_phase == 2'd1) n_state = S_MUL2;
            S_MUL2: if (r_cnt == 8'd1 && r_phase == 2'd1) n_state = S_SUB;
            S_SUB:  n_state = S_DIV;
            S_DIV:  if (r_cnt == 8'd127) n_state = (r_mode == MODE_STD) ? S_SQRT : S_FIN;
            S_SQRT: if (r_sb == 64'd0) n_state = S_FIN;
            S_FIN:  n_state = S_OUT;
            S_OUT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_mode  <= i_req.mode;
                r_neg   <= i_req.neg;
                r_n     <= {32'd0, i_req.n};
                r_mag   <= i_req.mag;
                r_cnt   <= 8'd0;
                r_phase <= 2'd0;
                r_prod  <= '0;
                r_rem   <= '0;
                r_q     <= '0;
                r_qhi   <= 1'b0;
                // n * sumsq first; mean divides (mag*256 + n/2) by n.
                r_b     <= {64'd0, {32'd0, i_req.n}};
                r_d     <= (i_req.mode == MODE_MEAN) ? {32'd0, i_req.n} : i_req.sqsum;
                r_a     <= {56'd0, i_req.mag, 8'd0} + {97'd0, i_req.n[31:1]};
            end
            S_MUL1, S_MUL2: begin
                // Four partial products (b half x d half), b held in r_b, d in r_d.
                if (r_phase == 2'd1 && r_cnt == 8'd1) begin
                    r_phase <= 2'd0;
                    r_cnt   <= 8'd0;
                    r_prod  <= '0;
                    if (r_state == S_MUL1) begin
                        r_a <= pp_sum;
                        r_b <= {64'd0, r_mag};
                        r_d <= r_mag;
                    end else begin
                        r_b <= pp_sum;
                        r_d <= r_n;
                    end
                end else if (r_phase == 2'd1) begin
                    r_prod  <= pp_sum;
                    r_phase <= 2'd0;
                    r_cnt   <= r_cnt + 8'd1;
                end else begin
                    r_prod  <= pp_sum;
                    r_phase <= r_phase + 2'd1;
                end
            end
            S_SUB: begin
                // Difference n*sumsq - sum^2, scaled, then divided by n*n.
                if (r_a < r_b) begin
                    r_a <= '0;
                end else if (r_mode == MODE_VAR) begin
                    r_a <= ((r_a - r_b) << 8) + {64'd0, nn_w >> 1};
                end else begin
                    r_a <= (r_a - r_b) << 16;
                end
                r_d <= nn_w;
            end
            S_DIV: begin
                r_rem <= div_take ? (div_shift[63:0] - r_d) : div_shift[63:0];
                r_a   <= r_a << 1;
                r_q   <= {r_q[62:0], div_take};
                if (r_q[63]) r_qhi <= 1'b1;
                r_cnt <= r_cnt + 8'd1;
                if (r_cnt == 8'd127) begin
                    r_sv <= (r_qhi || r_q[63]) ? '1 : {r_q[62:0], div_take};
                    r_x  <= (r_qhi || r_q[63]) ? '1 : {r_q[62:0], div_take};
                    r_sr <= '0;
                    r_sb <= 64'h4000_0000_0000_0000;
                end
            end
            S_SQRT: begin
                if (r_sb != 64'd0) begin
                    if (sq_ok) begin
                        r_sv <= r_sv - sq_t;
                        r_sr <= (r_sr >> 1) + r_sb;
                    end else begin
                        r_sr <= r_sr >> 1;
                    end
                end
                r_sb <= r_sb >> 2;
            end
            S_FIN: begin
                if (r_mode == MODE_STD) begin
                    r_x <= (r_sv > r_sr) ? r_sr + 64'd1 : r_sr;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_rsp.done = (r_state == S_OUT);
    assign o_rsp.mag  = r_x;
    assign o_rsp.neg  = (r_mode == MODE_MEAN) ? r_neg : 1'b0;

endmodule

[rtl/iws_ctrl.sv]
// Sequencer and accumulator memories: walks the interval table for samples, loads bounds and serves reads.
module iws_ctrl #(
    parameter int unsigned MAX_INTERVALS = iws_pkg::MAX_INTERVALS_DEF,
    parameter int unsigned MAX_CHANNELS  = iws_pkg::MAX_CHANNELS_DEF,
    parameter int unsigned COUNT_BITS    = iws_pkg::COUNT_BITS_DEF,
    parameter int unsigned VALUE_BITS    = iws_pkg::VALUE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    input  iws_pkg::t_req      i_req,
    input  logic [2:0]         i_stat_mode,
    input  logic [6:0]         i_interval_count,
    input  logic [3:0]         i_channel_count,
    output logic               o_busy,
    output logic               o_res_valid,
    output iws_pkg::t_res      o_res,
    output iws_pkg::t_calc_req o_calc,
    input  iws_pkg::t_calc_rsp i_calc
);
    import iws_pkg::*;

    localparam int unsigned IW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int unsigned CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int unsigned ENTRIES = MAX_INTERVALS * MAX_CHANNELS;
    localparam int unsigned EW = IW + CW;
    localparam int unsigned ACC_W = 1 + COUNT_BITS + SUM_W + SQ_W + 2 * VALUE_BITS;
    localparam int unsigned VSQ_W = 2 * VALUE_BITS;
    localparam logic [COUNT_BITS-1:0] FULL = '1;

    typedef struct packed {
        logic                         sat;
        logic [COUNT_BITS-1:0]        cnt;
        logic signed [SUM_W-1:0]      sum;
        logic [SQ_W-1:0]              sq;
        logic signed [VALUE_BITS-1:0] mn;
        logic signed [VALUE_BITS-1:0] mx;
    } t_acc;

    typedef enum logic [8:0] {
        S_CLEAR = 9'b0_0000_0001,
        S_IDLE  = 9'b0_0000_0010,
        S_WLOAD = 9'b0_0000_0100,
        S_SRD   = 9'b0_0000_1000,
        S_SUPD  = 9'b0_0001_0000,
        S_RRD   = 9'b0_0010_0000,
        S_RUSE  = 9'b0_0100_0000,
        S_CALC  = 9'b0_1000_0000,
        S_DONE  = 9'b1_0000_0000
    } t_state;

    // Interval bound table and accumulator table, one read port each.
    logic [63:0] bnd_mem [MAX_INTERVALS];
    logic [ACC_W-1:0] acc_mem [ENTRIES];
    logic [63:0]      bnd_q;
    logic [ACC_W-1:0] acc_q;
    logic [IW-1:0]    bnd_ra;
    logic [EW-1:0]    acc_ra, acc_wa;
    logic             acc_we;
    logic [ACC_W-1:0] acc_wd;

    t_state r_state, n_state;
    t_req   r_req;
    logic [IW:0] r_iv;        // interval counter during a walk or clearing pass
    logic [CW:0] r_ch;
    logic        r_hit_sat;
    logic        r_bad;
    t_res        r_res;
    logic        r_res_valid;
    logic [IW:0] lim_i;
    logic [CW:0] lim_c;
    logic        in_win;
    t_acc        cur, upd;
    logic signed [VALUE_BITS-1:0] v;
    logic [VALUE_BITS-1:0]        vabs;
    logic [VSQ_W-1:0]             vsq_n;
    logic [SQ_W-1:0]              vsq;
    logic [SQ_W:0]                sq_sum;
    logic [EW-1:0]                e_walk, e_load;

    assign lim_i = (i_interval_count > 7'(MAX_INTERVALS)) ? (IW+1)'(MAX_INTERVALS)
                                                          : (IW+1)'(i_interval_count);
    assign lim_c = (i_channel_count > 4'(MAX_CHANNELS)) ? (CW+1)'(MAX_CHANNELS)
                                                        : (CW+1)'(i_channel_count);

    always_ff @(posedge i_clk) begin
        if (acc_we) acc_mem[acc_wa] <= acc_wd;
        acc_q <= acc_mem[acc_ra];
        if (r_state == S_WLOAD && !r_bad)
            bnd_mem[r_req.interval_index[IW-1:0]] <= {r_req.start_time, r_req.end_time};
        bnd_q <= bnd_mem[bnd_ra];
    end

    assign v      = r_req.sample_value[VALUE_BITS-1:0];
    assign vabs   = v[VALUE_BITS-1] ? VALUE_BITS'(-v) : VALUE_BITS'(v);
    assign vsq_n  = VSQ_W'(vabs) * VSQ_W'(vabs);
    assign vsq    = SQ_W'(vsq_n);
    assign cur    = acc_q;
    assign sq_sum = {1'b0, cur.sq} + {1'b0, vsq};
    assign in_win = (r_req.sample_time >= bnd_q[63:32]) && (r_req.sample_time < bnd_q[31:0]);
    assign e_walk = EW'(r_iv[IW-1:0] * MAX_CHANNELS) + EW'(r_req.channel_index[CW-1:0]);
    assign e_load = EW'(r_req.interval_index[IW-1:0] * MAX_CHANNELS) + EW'(r_ch[CW-1:0]);

    always_comb begin
        upd = cur;
        if (cur.cnt == FULL) begin
            upd.sat = 1'b1;
        end else begin
            upd.cnt = cur.cnt + COUNT_BITS'(1);
            upd.sum = cur.sum + SUM_W'(v);
            upd.sq  = sq_sum[SQ_W] ? '1 : sq_sum[SQ_W-1:0];
            if (cur.cnt == '0 || v < cur.mn) upd.mn = v;
            if (cur.cnt == '0 || v > cur.mx) upd.mx = v;
        end
    end

    always_comb begin
        acc_ra = e_walk;
        bnd_ra = r_iv[IW-1:0];
        acc_we = 1'b0;
        acc_wa = e_walk;
        acc_wd = upd;
        case (r_state)
            S_CLEAR: begin
                acc_we = 1'b1;
                acc_wa = r_iv[IW-1:0] * EW'(MAX_CHANNELS) + EW'(r_ch[CW-1:0]);
                acc_wd = '0;
            end
            S_WLOAD: begin
                acc_we = !r_bad;
                acc_wa = e_load;
                acc_wd = '0;
            end
            S_SUPD: acc_we = in_win;
            S_RRD, S_RUSE: acc_ra = EW'(r_req.interval_index[IW-1:0] * MAX_CHANNELS)
                                  + EW'(r_req.channel_index[CW-1:0]);
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_iv        <= '0;
            r_ch        <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= (n_state == S_DONE);
            case (r_state)
                S_CLEAR: begin
                    r_ch <= r_ch + 1'b1;
                    if (r_ch == (CW+1)'(MAX_CHANNELS - 1)) begin
                        r_ch <= '0;
                        r_iv <= r_iv + 1'b1;
                    end
                end
                S_IDLE: begin
                    r_iv <= '0;
                    r_ch <= '0;
                end
                S_WLOAD: r_ch <= r_ch + 1'b1;
                S_SUPD:  r_iv <= r_iv + 1'b1;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_iv == (IW+1)'(MAX_INTERVALS - 1)
                         && r_ch == (CW+1)'(MAX_CHANNELS - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (i_go) begin
                    case (i_req.req_type)
                        REQ_LOAD:   n_state = S_WLOAD;
                        REQ_SAMPLE: n_state = S_SRD;
                        REQ_READ:   n_state = S_RRD;
                        default:    n_state = S_RRD;
                    endcase
                end
            end
            S_WLOAD: if (r_bad || r_ch == (CW+1)'(MAX_CHANNELS - 1)) n_state = S_DONE;
            S_SRD:   n_state = (r_bad || r_iv >= lim_i) ? S_DONE : S_SUPD;
            S_SUPD:  n_state = S_SRD;
            S_RRD:   n_state = r_bad ? S_DONE : S_RUSE;
            S_RUSE:  n_state = (cur.cnt == '0 || r_req.req_type != REQ_READ
                                || i_stat_mode == MODE_MIN || i_stat_mode == MODE_MAX)
                               ? S_DONE : S_CALC;
            S_CALC:  if (i_calc.done) n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Request capture, refusal check and result assembly.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_req     <= i_req;
                r_hit_sat <= 1'b0;
                r_res     <= '0;
                case (i_req.req_type)
                    REQ_LOAD:   r_bad <= ({1'b0, i_req.interval_index} >= 7'(lim_i))
                                         || (i_req.end_time < i_req.start_time);
                    REQ_SAMPLE: r_bad <= ({1'b0, i_req.channel_index} >= 4'(lim_c));
                    REQ_READ:   r_bad <= ({1'b0, i_req.interval_index} >= 7'(lim_i))
                                         || ({1'b0, i_req.channel_index} >= 4'(lim_c))
                                         || (i_stat_mode > MODE_MAX);
                    default:    r_bad <= 1'b1;
                endcase
            end
            S_SUPD: if (in_win && cur.cnt == FULL) r_hit_sat <= 1'b1;
            S_RUSE: begin
                r_res.count_saturated <= cur.sat;
                r_res.empty_interval  <= (cur.cnt == '0);
                if (i_stat_mode == MODE_MIN && cur.cnt != '0)
                    r_res.result_value <= RES_W'(cur.mn) <<< 8;
                if (i_stat_mode == MODE_MAX && cur.cnt != '0)
                    r_res.result_value <= RES_W'(cur.mx) <<< 8;
            end
            S_CALC: begin
                if (i_calc.done) begin
                    if (i_calc.neg) begin
                        r_res.result_value <= (i_calc.mag > 64'h0000_8000_0000_0000)
                            ? 48'sh8000_0000_0000 : -RES_W'(i_calc.mag);
                    end else begin
                        r_res.result_value <= (i_calc.mag > 64'h0000_7FFF_FFFF_FFFF)
                            ? 48'sh7FFF_FFFF_FFFF : RES_W'(i_calc.mag);
                    end
                end
            end
            default: begin
            end
        endcase
        if (n_state == S_DONE && r_state != S_DONE) begin
            if (r_bad) begin
                r_res <= '{bad_request: 1'b1, default: '0};
            end else if (r_req.req_type == REQ_SAMPLE) begin
                r_res.count_saturated <= r_hit_sat;
            end
        end
    end

    logic [SUM_W-1:0] smag;
    assign smag = cur.sum[SUM_W-1] ? SUM_W'(-cur.sum) : SUM_W'(cur.sum);

    assign o_calc.go    = (r_state == S_RUSE) && (n_state == S_CALC);
    assign o_calc.mode  = i_stat_mode;
    assign o_calc.n     = 32'(cur.cnt);
    assign o_calc.neg   = cur.sum[SUM_W-1];
    assign o_calc.mag   = 64'(smag);
    assign o_calc.sqsum = 64'(cur.sq);

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

[rtl/interval_window_statistics_top.sv]
// Top level of the interval window statistics block: register port, sequencer and arithmetic.
//
//  Channel   Direction  Beat marked by             Payload
//  request   in         start & !busy              i_req (t_req)
//  result    out        o_done                     o_res (t_res)
//  config    in         psel&penable&pwrite        pwdata at paddr
//
// A sample walks every interval in use; each interval costs one read of the accumulator
// memory and, when the sample time falls inside its window, one write. Reads of the
// mean, variance and standard deviation go through the arithmetic unit, whose divider
// and square-root unit work one bit a cycle; a read of the minimum or maximum does not.
// After reset a clearing pass writes every accumulator entry, one per cycle; busy stays
// high meanwhile. The result is shown for one cycle and cannot be stalled by the receiver.
module interval_window_statistics_top #(
    parameter int unsigned MAX_INTERVALS = iws_pkg::MAX_INTERVALS_DEF,
    parameter int unsigned MAX_CHANNELS  = iws_pkg::MAX_CHANNELS_DEF,
    parameter int unsigned COUNT_BITS    = iws_pkg::COUNT_BITS_DEF,
    parameter int unsigned VALUE_BITS    = iws_pkg::VALUE_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  iws_pkg::t_req i_req,
    output logic          o_done,
    output iws_pkg::t_res o_res,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import iws_pkg::*;

    logic [2:0] r_stat_mode;
    logic [6:0] r_interval_count;
    logic [3:0] r_channel_count;
    logic       wr;
    t_calc_req  calc_req;
    t_calc_rsp  calc_rsp;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    // Configuration registers; the user writes only while the block is idle; not enforced.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stat_mode      <= MODE_MEAN;
            r_interval_count <= 7'd1;
            r_channel_count  <= 4'd1;
        end else if (wr) begin
            case (paddr[3:2])
                REG_STAT_MODE:    r_stat_mode      <= pwdata[2:0];
                REG_INTERVAL_CNT: r_interval_count <= pwdata[6:0];
                REG_CHANNEL_CNT:  r_channel_count  <= pwdata[3:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_STAT_MODE:    prdata = {29'd0, r_stat_mode};
            REG_INTERVAL_CNT: prdata = {25'd0, r_interval_count};
            REG_CHANNEL_CNT:  prdata = {28'd0, r_channel_count};
            default:          prdata = 32'd0;
        endcase
    end

    iws_ctrl #(
        .MAX_INTERVALS (MAX_INTERVALS),
        .MAX_CHANNELS  (MAX_CHANNELS),
        .COUNT_BITS    (COUNT_BITS),
        .VALUE_BITS    (VALUE_BITS)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_go             (start && !busy),
        .i_req            (i_req),
        .i_stat_mode      (r_stat_mode),
        .i_interval_count (r_interval_count),
        .i_channel_count  (r_channel_count),
        .o_busy           (busy),
        .o_res_valid      (o_done),
        .o_res            (o_res),
        .o_calc           (calc_req),
        .i_calc           (calc_rsp)
    );

    iws_calc u_calc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (calc_req),
        .o_rsp   (calc_rsp)
    );

endmodule
